@@ sv/ppp_pkg.sv @@
// shared types and constants for the particle pool physics step block
// no dependencies; imported by ppp_ctrl, ppp_dpath and the top level
package ppp_pkg;

    localparam int POOL_DEPTH_DEF = 512;
    localparam int SINE_STEPS_DEF = 1024;

    localparam logic [7:0]  GRAVITY_RST = 8'd77;
    localparam logic [8:0]  DRAG_RST    = 9'd254;
    localparam logic [9:0]  PHASE_RST   = 10'd24;
    localparam logic [10:0] BOTTOM_RST  = 11'd478;

    localparam logic [7:0] LIFE_START = 8'd255;
    localparam int CFG_DW = 11;
    localparam int CNT_OW = 10;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SPAWN = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd_code;

    typedef enum logic [1:0] {
        CFG_GRAVITY = 2'd0,
        CFG_DRAG    = 2'd1,
        CFG_PHASE   = 2'd2,
        CFG_BOTTOM  = 2'd3
    } t_cfg_idx;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic rd_tick;
        logic clr_wr;
        logic spawn_wr;
        logic cnt_clr;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic probe_free;
        logic full;
    } t_dp_stat;

endpackage

@@ sv/ppp_dpath.sv @@
// particle memory, update pipeline, sine rom, config and alive counter
// depends on ppp_pkg
module ppp_dpath #(
    parameter int POOL_DEPTH = ppp_pkg::POOL_DEPTH_DEF,
    parameter int SINE_STEPS = ppp_pkg::SINE_STEPS_DEF,
    parameter int AW = $clog2(POOL_DEPTH),
    parameter int CW = $clog2(POOL_DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ppp_pkg::t_dp_cmd         i_cmd,
    input  logic [AW-1:0]            i_rd_addr,
    input  logic [AW-1:0]            i_wr_addr,
    output ppp_pkg::t_dp_stat        o_stat,
    output logic [AW-1:0]            o_probe_addr,
    output logic [CW-1:0]            o_alive,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_idx,
    input  logic [ppp_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic signed [19:0]       i_spawn_x,
    input  logic signed [19:0]       i_spawn_y,
    input  logic signed [15:0]       i_spawn_vx,
    input  logic signed [15:0]       i_spawn_vy,
    input  logic [9:0]               i_spawn_phase,
    input  logic [9:0]               i_spawn_amplitude,
    input  logic [7:0]               i_spawn_decay
);
    import ppp_pkg::*;

    localparam int PHW  = $clog2(SINE_STEPS);
    localparam int HALF = SINE_STEPS / 2;
    localparam int PSW  = ((PHW > 10) ? PHW : 10) + 1;

    typedef struct packed {
        logic               active;
        logic signed [19:0] xpos;
        logic signed [19:0] ypos;
        logic signed [15:0] xvel;
        logic signed [15:0] yvel;
        logic [PHW-1:0]     phase;
        logic [9:0]         amp;
        logic [7:0]         life;
        logic [7:0]         decay;
    } t_word;

    typedef logic [8:0] t_rom [HALF];

    // sine magnitude for k = 0..half-1, long division done at elaboration
    function automatic t_rom f_build_rom();
        t_rom   rom;
        longint h;
        longint v;
        longint den;
        longint num;
        longint q;
        h = longint'(HALF);
        for (int k = 0; k < HALF; k++) begin
            v   = longint'(k) * (h - longint'(k));
            den = 5 * h * h - 4 * v;
            num = 4096 * v;
            q   = 0;
            for (int b = 8; b >= 0; b--) begin
                if (num >= (den <<< b)) begin
                    num = num - (den <<< b);
                    q   = q + (longint'(1) <<< b);
                end
            end
            rom[k] = 9'(q);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = f_build_rom();

    // config
    logic [7:0]  r_grav;
    logic [8:0]  r_drag;
    logic [9:0]  r_pstep;
    logic [10:0] r_bottom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav   <= GRAVITY_RST;
            r_drag   <= DRAG_RST;
            r_pstep  <= PHASE_RST;
            r_bottom <= BOTTOM_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GRAVITY: r_grav   <= i_cfg_data[7:0];
                CFG_DRAG:    r_drag   <= i_cfg_data[8:0];
                CFG_PHASE:   r_pstep  <= i_cfg_data[9:0];
                CFG_BOTTOM:  r_bottom <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // spawn item held for the probe
    t_word r_spawn;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_spawn.active <= 1'b1;
            r_spawn.xpos   <= i_spawn_x;
            r_spawn.ypos   <= i_spawn_y;
            r_spawn.xvel   <= i_spawn_vx;
            r_spawn.yvel   <= i_spawn_vy;
            r_spawn.phase  <= PHW'(i_spawn_phase);
            r_spawn.amp    <= i_spawn_amplitude;
            r_spawn.life   <= LIFE_START;
            r_spawn.decay  <= i_spawn_decay;
        end
    end

    // pipeline registers
    t_word                r_rd;
    logic                 r_s1_vld, r_s1_tick;
    logic [AW-1:0]        r_s1_addr;
    t_word                r_s2;
    logic                 r_s2_vld, r_s2_neg;
    logic [AW-1:0]        r_s2_addr;
    logic signed [25:0]   r_s2_prod;
    logic [8:0]           r_mag;
    t_word                r_s3;
    logic                 r_s3_vld;
    logic [AW-1:0]        r_s3_addr;
    logic signed [20:0]   r_s3_sprod;

    t_word r_mem [POOL_DEPTH];

    // stage 1: gravity, drag product, phase advance
    logic signed [16:0] s1_ysum;
    logic signed [15:0] s1_yvel;
    logic signed [25:0] s1_prod;
    logic [PSW-1:0]     s1_psum;
    logic [PHW-1:0]     s1_phase;
    t_word              s1_word;

    always_comb begin
        s1_ysum  = {r_rd.yvel[15], r_rd.yvel} + {9'd0, r_grav};
        s1_yvel  = (s1_ysum[16] != s1_ysum[15]) ? 16'sh7fff : s1_ysum[15:0];
        s1_prod  = r_rd.xvel * $signed({1'b0, r_drag});
        s1_psum  = PSW'(r_rd.phase) + PSW'(r_pstep);
        s1_phase = s1_psum[PHW-1:0];
        s1_word       = r_rd;
        s1_word.yvel  = s1_yvel;
        s1_word.phase = s1_phase;
    end

    // stage 2: drag saturation, signed sine times amplitude
    logic signed [17:0] s2_xq;
    logic signed [15:0] s2_xvel;
    logic signed [9:0]  s2_sin;
    logic signed [20:0] s2_sprod;
    t_word              s2_word;

    always_comb begin
        s2_xq = 18'(r_s2_prod >>> 8);
        if (s2_xq > 18'sd32767) begin
            s2_xvel = 16'sh7fff;
        end else if (s2_xq < -18'sd32768) begin
            s2_xvel = 16'sh8000;
        end else begin
            s2_xvel = s2_xq[15:0];
        end
        s2_sin   = r_s2_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
        s2_sprod = s2_sin * $signed({1'b0, r_s2.amp});
        s2_word      = r_s2;
        s2_word.xvel = s2_xvel;
    end

    // stage 3: positions, life, retire, write back
    logic signed [12:0] s3_sway;
    logic signed [21:0] s3_xsum;
    logic signed [20:0] s3_ysum;
    logic signed [19:0] s3_xpos, s3_ypos;
    logic               s3_retire, s3_wr;
    t_word              s3_word;

    always_comb begin
        s3_sway = 13'(r_s3_sprod >>> 8);
        s3_xsum = 22'(r_s3.xpos) + 22'(r_s3.xvel) + 22'(s3_sway);
        s3_ysum = 21'(r_s3.ypos) + 21'(r_s3.yvel);
        if (s3_xsum > 22'sd524287) begin
            s3_xpos = 20'sh7ffff;
        end else if (s3_xsum < -22'sd524288) begin
            s3_xpos = 20'sh80000;
        end else begin
            s3_xpos = s3_xsum[19:0];
        end
        if (s3_ysum > 21'sd524287) begin
            s3_ypos = 20'sh7ffff;
        end else if (s3_ysum < -21'sd524288) begin
            s3_ypos = 20'sh80000;
        end else begin
            s3_ypos = s3_ysum[19:0];
        end
        s3_retire = (r_s3.life <= r_s3.decay)
                 || (21'(s3_ypos) > $signed({2'b00, r_bottom, 8'd0}));
        s3_word        = r_s3;
        s3_word.active = !s3_retire;
        s3_word.xpos   = s3_xpos;
        s3_word.ypos   = s3_ypos;
        s3_word.life   = r_s3.life - r_s3.decay;
        s3_wr          = r_s3_vld && r_s3.active;
    end

    // write port mux: controller keeps the sources apart
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_word         mem_wdata;

    always_comb begin
        mem_we    = 1'b1;
        mem_waddr = i_wr_addr;
        mem_wdata = '0;
        if (s3_wr) begin
            mem_waddr = r_s3_addr;
            mem_wdata = s3_word;
        end else if (i_cmd.spawn_wr) begin
            mem_wdata = r_spawn;
        end else if (!i_cmd.clr_wr) begin
            mem_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= SINE_ROM[s1_phase[PHW-2:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.rd_en;
            r_s2_vld <= r_s1_vld && r_s1_tick;
            r_s3_vld <= r_s2_vld;
        end
        r_s1_tick     <= i_cmd.rd_tick;
        r_s1_addr     <= i_rd_addr;
        r_s2          <= s1_word;
        r_s2_neg      <= s1_phase[PHW-1];
        r_s2_prod     <= s1_prod;
        r_s2_addr     <= r_s1_addr;
        r_s3          <= s2_word;
        r_s3_sprod    <= s2_sprod;
        r_s3_addr     <= r_s2_addr;
    end

    // alive counter
    logic [CW-1:0] r_alive;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.cnt_clr) begin
            r_alive <= '0;
        end else if (i_cmd.spawn_wr) begin
            r_alive <= r_alive + 1'b1;
        end else if (s3_wr && s3_retire) begin
            r_alive <= r_alive - 1'b1;
        end
    end

    assign o_alive          = r_alive;
    assign o_probe_addr     = r_s1_addr;
    assign o_stat.full      = (r_alive == CW'(POOL_DEPTH));
    assign o_stat.probe_free = r_s1_vld && !r_s1_tick && !r_rd.active;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alive <= CW'(POOL_DEPTH))
        else $error("alive counter above pool depth");

    a_spawn_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.spawn_wr |-> !o_stat.full)
        else $error("spawn write into a full pool");

    a_wr_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s3_wr |-> !(i_cmd.spawn_wr || i_cmd.clr_wr))
        else $error("update write collides with spawn or clear");

endmodule

@@ sv/ppp_ctrl.sv @@
// sequencer for sweeps, spawn probe and result register
// depends on ppp_pkg
module ppp_ctrl #(
    parameter int POOL_DEPTH = ppp_pkg::POOL_DEPTH_DEF,
    parameter int AW = $clog2(POOL_DEPTH),
    parameter int CW = $clog2(POOL_DEPTH + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_cmd,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [ppp_pkg::CNT_OW-1:0] o_alive_count,
    output logic                       o_dropped,
    output ppp_pkg::t_dp_cmd           o_dp_cmd,
    output logic [AW-1:0]              o_rd_addr,
    output logic [AW-1:0]              o_wr_addr,
    input  ppp_pkg::t_dp_stat          i_stat,
    input  logic [AW-1:0]              i_probe_addr,
    input  logic [CW-1:0]              i_alive
);
    import ppp_pkg::*;

    localparam logic [AW-1:0] LAST = AW'(POOL_DEPTH - 1);

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_TICK, S_DRAIN, S_PROBE, S_CLR, S_DONE
    } t_state;

    t_state               r_state;
    logic [AW-1:0]        r_cnt;
    logic                 r_drop;
    logic                 r_out_vld;
    logic                 r_out_drop;
    logic [CNT_OW-1:0]    r_out_count;
    logic                 out_free;

    assign out_free = !r_out_vld || i_out_ready;

    always_comb begin
        o_dp_cmd          = '0;
        o_dp_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_dp_cmd.rd_en    = (r_state == S_TICK) || (r_state == S_PROBE);
        o_dp_cmd.rd_tick  = (r_state == S_TICK);
        o_dp_cmd.clr_wr   = (r_state == S_INIT) || (r_state == S_CLR);
        o_dp_cmd.cnt_clr  = o_dp_cmd.clr_wr;
        o_dp_cmd.spawn_wr = (r_state == S_PROBE) && i_stat.probe_free;
        o_rd_addr         = r_cnt;
        o_wr_addr         = (r_state == S_PROBE) ? i_probe_addr : r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_cnt     <= '0;
            r_drop    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cnt  <= '0;
                        r_drop <= 1'b0;
                        case (t_cmd_code'(i_cmd))
                            CMD_TICK:  r_state <= S_TICK;
                            CMD_CLEAR: r_state <= S_CLR;
                            CMD_SPAWN: begin
                                if (i_stat.full) begin
                                    r_drop  <= 1'b1;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_PROBE;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_TICK: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == AW'(2)) begin
                        r_state <= S_DONE;
                    end
                end
                S_PROBE: begin
                    if (i_stat.probe_free) begin
                        r_state <= S_DONE;
                    end else if (r_cnt != LAST) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_drop  <= r_drop;
                        r_out_count <= CNT_OW'(i_alive);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_INIT;
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_vld;
    assign o_dropped     = r_out_drop;
    assign o_alive_count = r_out_count;

endmodule

@@ sv/particle_pool_physics_step_top.sv @@
// top level of the particle pool physics step block
// depends on ppp_pkg, ppp_ctrl and ppp_dpath
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------
//  input    | i_in_valid / o_in_ready   | i_cmd, i_spawn_x .. i_spawn_decay
//  result   | o_out_valid / i_out_ready | o_alive_count, o_dropped
//  config   | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// tick: one particle read per cycle from the single read port
// spawn: the probe scans from slot 0 up to the lowest free slot; a full pool answers without a probe
// clear: one entry written per cycle
// after reset a clearing pass over every entry runs with o_in_ready low
// a finished result waits in the output register; the next transfer can start meanwhile
// SINE_STEPS must be a power of two
module particle_pool_physics_step_top #(
    parameter int POOL_DEPTH = ppp_pkg::POOL_DEPTH_DEF,
    parameter int SINE_STEPS = ppp_pkg::SINE_STEPS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_cmd,
    input  logic signed [19:0]           i_spawn_x,
    input  logic signed [19:0]           i_spawn_y,
    input  logic signed [15:0]           i_spawn_vx,
    input  logic signed [15:0]           i_spawn_vy,
    input  logic [9:0]                   i_spawn_phase,
    input  logic [9:0]                   i_spawn_amplitude,
    input  logic [7:0]                   i_spawn_decay,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [ppp_pkg::CNT_OW-1:0]   o_alive_count,
    output logic                         o_dropped,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [ppp_pkg::CFG_DW-1:0]   i_cfg_data
);
    import ppp_pkg::*;

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);

    // command and status between sequencer and datapath
    t_dp_cmd       dp_cmd;
    t_dp_stat      dp_stat;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] probe_addr;
    logic [CW-1:0] alive;

    // sequencer: sweeps, probe and output register
    ppp_ctrl #(
        .POOL_DEPTH (POOL_DEPTH),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_alive_count (o_alive_count),
        .o_dropped     (o_dropped),
        .o_dp_cmd      (dp_cmd),
        .o_rd_addr     (rd_addr),
        .o_wr_addr     (wr_addr),
        .i_stat        (dp_stat),
        .i_probe_addr  (probe_addr),
        .i_alive       (alive)
    );

    // datapath: particle memory, update pipeline, config registers
    ppp_dpath #(
        .POOL_DEPTH (POOL_DEPTH),
        .SINE_STEPS (SINE_STEPS),
        .AW         (AW),
        .CW         (CW)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .i_rd_addr         (rd_addr),
        .i_wr_addr         (wr_addr),
        .o_stat            (dp_stat),
        .o_probe_addr      (probe_addr),
        .o_alive           (alive),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_spawn_x         (i_spawn_x),
        .i_spawn_y         (i_spawn_y),
        .i_spawn_vx        (i_spawn_vx),
        .i_spawn_vy        (i_spawn_vy),
        .i_spawn_phase     (i_spawn_phase),
        .i_spawn_amplitude (i_spawn_amplitude),
        .i_spawn_decay     (i_spawn_decay)
    );

endmodule

@@ sim/particle_pool_physics_step_top_tb.sv @@
// testbench for particle_pool_physics_step_top: directed table, pool fill, then random commands,
// each result checked against a behavioral pool model or a typed-in value; depends on ppp_pkg and the rtl
`timescale 1ns / 100ps

module particle_pool_physics_step_top_tb;
    import ppp_pkg::*;

    localparam int DEPTH = POOL_DEPTH_DEF;
    localparam int STEPS = SINE_STEPS_DEF;
    localparam int N_RAND = 624;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [1:0]           i_cmd;
    logic signed [19:0]   i_spawn_x;
    logic signed [19:0]   i_spawn_y;
    logic signed [15:0]   i_spawn_vx;
    logic signed [15:0]   i_spawn_vy;
    logic [9:0]           i_spawn_phase;
    logic [9:0]           i_spawn_amplitude;
    logic [7:0]           i_spawn_decay;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [CNT_OW-1:0]    o_alive_count;
    logic                 o_dropped;
    logic                 i_cfg_we;
    logic [1:0]           i_cfg_idx;
    logic [CFG_DW-1:0]    i_cfg_data;

    particle_pool_physics_step_top dut (.*);

    // one command with its spawn payload
    typedef struct {
        logic [1:0]  cmd;
        logic [19:0] x, y;
        logic [15:0] vx, vy;
        logic [9:0]  ph, amp;
        logic [7:0]  dec;
    } t_item;

    typedef struct {
        logic [CNT_OW-1:0] count;
        logic              drop;
    } t_status;

    // directed row; chk_count < 0 means take the model's answer
    typedef struct {
        t_item item;
        int    chk_count;
        int    chk_drop;
    } t_row;

    // shadow configuration
    logic [7:0]  grav_sh;
    logic [8:0]  drag_sh;
    logic [9:0]  pstep_sh;
    logic [10:0] bottom_sh;

    // shadow pool
    bit          act[DEPTH];
    int          px[DEPTH], py[DEPTH], vx[DEPTH], vy[DEPTH];
    int          ph[DEPTH], amp[DEPTH], life[DEPTH], dec[DEPTH];
    int          n_alive;

    t_status     pending_status[$];
    int          n_fail;

    always #10 i_clk = ~i_clk;

    function automatic int floor256(longint v);
        if (v >= 0) return int'(v / 256);
        return int'(-((-v + 255) / 256));
    endfunction

    function automatic int clamp(longint v, longint lo, longint hi);
        if (v < lo) return int'(lo);
        if (v > hi) return int'(hi);
        return int'(v);
    endfunction

    // rational (Bhaskara) sine approximation, Q1.8
    function automatic int sway_sine(int phase);
        longint h, p, k, v, s;
        bit      neg;
        h = STEPS / 2;
        p = phase % STEPS;
        neg = (p >= h);
        k = neg ? p - h : p;
        v = k * (h - k);
        s = (4096 * v) / (5 * h * h - 4 * v);
        return neg ? -int'(s) : int'(s);
    endfunction

    function automatic t_status pool_apply(t_item it);
        t_status r;
        int      i;
        r.drop = 0;
        case (it.cmd)
            CMD_TICK: begin
                for (i = 0; i < DEPTH; i++) begin
                    if (act[i]) begin
                        vy[i] = clamp(longint'(vy[i]) + grav_sh, -32768, 32767);
                        vx[i] = clamp(floor256(longint'(vx[i]) * drag_sh), -32768, 32767);
                        ph[i] = (ph[i] + pstep_sh) % STEPS;
                        px[i] = clamp(longint'(px[i]) + vx[i]
                                      + floor256(longint'(sway_sine(ph[i])) * amp[i]),
                                      -524288, 524287);
                        py[i] = clamp(longint'(py[i]) + vy[i], -524288, 524287);
                        if (life[i] <= dec[i]) begin
                            act[i] = 0;
                            n_alive--;
                        end else begin
                            life[i] -= dec[i];
                            if (longint'(py[i]) > longint'(bottom_sh) * 256) begin
                                act[i] = 0;
                                n_alive--;
                            end
                        end
                    end
                end
            end
            CMD_SPAWN: begin
                for (i = 0; i < DEPTH; i++)
                    if (!act[i]) break;
                if (i >= DEPTH) begin
                    r.drop = 1;
                end else begin
                    px[i] = $signed(it.x);
                    py[i] = $signed(it.y);
                    vx[i] = $signed(it.vx);
                    vy[i] = $signed(it.vy);
                    ph[i] = it.ph % STEPS;
                    amp[i] = it.amp;
                    dec[i] = it.dec;
                    life[i] = 255;
                    act[i] = 1;
                    n_alive++;
                end
            end
            CMD_CLEAR: begin
                for (i = 0; i < DEPTH; i++) act[i] = 0;
                n_alive = 0;
            end
            default: ;
        endcase
        r.count = n_alive[CNT_OW-1:0];
        return r;
    endfunction

    // gap length: mostly zero or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_item rand_spawn();
        t_item it;
        int    r;
        it.cmd = CMD_SPAWN;
        it.x   = 20'($urandom);
        it.y   = 20'($urandom);
        it.vx  = 16'($urandom);
        it.vy  = 16'($urandom);
        it.ph  = 10'($urandom);
        it.amp = 10'($urandom);
        it.dec = 8'($urandom);
        r = $urandom_range(0, 3);
        // plausible on-screen particles most of the time so they live a while
        if (r != 0) begin
            it.y   = 20'($urandom_range(0, 400 * 256));
            it.x   = 20'($urandom_range(0, 640 * 256));
            it.vy  = 16'($signed($urandom_range(0, 1024)) - 512);
            it.dec = 8'($urandom_range(0, 20));
        end
        return it;
    endfunction

    task automatic cfg_write(t_cfg_idx idx, int val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DW'(val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_GRAVITY: grav_sh   = 8'(val);
            CFG_DRAG:    drag_sh   = 9'(val);
            CFG_PHASE:   pstep_sh  = 10'(val);
            default:     bottom_sh = 11'(val);
        endcase
    endtask

    // stop driving, wait for every expected status, then the block's longest pass
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 20) @(posedge i_clk);
    endtask

    // one input transfer; the expectation is queued at the accepting edge
    task automatic send(t_item it, int chk_count, int chk_drop);
        t_status s;
        int      gap;
        gap = idle_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_cmd             <= it.cmd;
        i_spawn_x         <= it.x;
        i_spawn_y         <= it.y;
        i_spawn_vx        <= it.vx;
        i_spawn_vy        <= it.vy;
        i_spawn_phase     <= it.ph;
        i_spawn_amplitude <= it.amp;
        i_spawn_decay     <= it.dec;
        do @(posedge i_clk); while (!o_in_ready);
        s = pool_apply(it);
        // typed-in rows are checked against the typed value
        if (chk_count >= 0) begin
            s.count = CNT_OW'(chk_count);
            s.drop  = chk_drop[0];
        end
        pending_status.push_back(s);
        @(negedge i_clk);
    endtask

    // result side: random stalls, compare against the oldest expectation
    initial begin
        t_status s;
        int      gap;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = idle_len();
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                if (pending_status.size() == 0) begin
                    $error("result transfer with nothing expected");
                    n_fail++;
                end else begin
                    s = pending_status.pop_front();
                    if (o_alive_count !== s.count) begin
                        $error("alive_count exp %0d got %0d", s.count, o_alive_count);
                        n_fail++;
                    end
                    if (o_dropped !== s.drop) begin
                        $error("dropped exp %0d got %0d", s.drop, o_dropped);
                        n_fail++;
                    end
                end
            end
        end
    end

    // stimulus
    initial begin
        t_row  rows[$];
        t_row  row;
        t_item it;
        int    k, r, phase_no;

        i_clk = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_cmd = CMD_TICK;
        i_spawn_x = '0;
        i_spawn_y = '0;
        i_spawn_vx = '0;
        i_spawn_vy = '0;
        i_spawn_phase = '0;
        i_spawn_amplitude = '0;
        i_spawn_decay = '0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_GRAVITY;
        i_cfg_data = '0;
        n_fail = 0;
        grav_sh = GRAVITY_RST;
        drag_sh = DRAG_RST;
        pstep_sh = PHASE_RST;
        bottom_sh = BOTTOM_RST;
        n_alive = 0;
        foreach (act[k]) act[k] = 0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        it = '{CMD_TICK, 0, 0, 0, 0, 0, 0, 0};
        row = '{it, 0, 0};                               rows.push_back(row); // empty tick
        it.cmd = CMD_UNUSED; row = '{it, 0, 0};          rows.push_back(row); // unused command
        it = '{CMD_SPAWN, 20'h7FFFF, 20'h7FFFF, 16'h7FFF, 16'h7FFF, 10'h3FF, 10'h3FF, 8'hFF};
        row = '{it, 1, 0};                               rows.push_back(row); // max fields
        it = '{CMD_SPAWN, 20'h80000, 20'h80000, 16'h8000, 16'h8000, 10'd0, 10'd0, 8'd0};
        row = '{it, 2, 0};                               rows.push_back(row); // min, no decay
        it = '{CMD_SPAWN, 20'h0, 20'h0, 16'h8000, 16'h7F00, 10'd512, 10'h3FF, 8'd0};
        row = '{it, 3, 0};                               rows.push_back(row);
        it = '{CMD_SPAWN, 20'h0, 20'h100, 16'h0100, 16'h0, 10'd255, 10'd600, 8'd1};
        row = '{it, 4, 0};                               rows.push_back(row);
        it = '{CMD_TICK, 0, 0, 0, 0, 0, 0, 0};
        row = '{it, -1, 0};                              rows.push_back(row);
        row = '{it, -1, 0};                              rows.push_back(row);
        it.cmd = CMD_UNUSED; row = '{it, -1, 0};         rows.push_back(row);
        it.cmd = CMD_CLEAR; row = '{it, 0, 0};           rows.push_back(row);
        it = '{CMD_SPAWN, 20'h1000, 20'h1000, 16'h0, 16'h0, 10'd767, 10'd256, 8'd255};
        row = '{it, 1, 0};                               rows.push_back(row);
        it.cmd = CMD_TICK; row = '{it, 0, 0};            rows.push_back(row); // life ends
        foreach (rows[k]) send(rows[k].item, rows[k].chk_count, rows[k].chk_drop);

        // fill the pool and spawn past full
        drain();
        cfg_write(CFG_BOTTOM, 2047);
        for (k = 0; k < DEPTH; k++) begin
            it = rand_spawn();
            it.dec = 0;
            send(it, -1, 0);
        end
        it = rand_spawn();
        send(it, DEPTH, 1);
        it.cmd = CMD_TICK;
        send(it, -1, 0);
        it.cmd = CMD_CLEAR;
        send(it, 0, 0);

        // random phases over several register settings
        for (phase_no = 0; phase_no < 6; phase_no++) begin
            drain();
            case (phase_no)
                0: begin
                    cfg_write(CFG_GRAVITY, 0);   cfg_write(CFG_DRAG, 0);
                    cfg_write(CFG_PHASE, 0);     cfg_write(CFG_BOTTOM, 0);
                end
                1: begin
                    cfg_write(CFG_GRAVITY, 255); cfg_write(CFG_DRAG, 511);
                    cfg_write(CFG_PHASE, 1023);  cfg_write(CFG_BOTTOM, 2047);
                end
                2: begin
                    cfg_write(CFG_GRAVITY, 77);  cfg_write(CFG_DRAG, 256);
                    cfg_write(CFG_PHASE, 24);    cfg_write(CFG_BOTTOM, 478);
                end
                default: begin
                    cfg_write(CFG_GRAVITY, $urandom_range(0, 255));
                    cfg_write(CFG_DRAG, $urandom_range(0, 511));
                    cfg_write(CFG_PHASE, $urandom_range(0, 1023));
                    cfg_write(CFG_BOTTOM, $urandom_range(0, 2047));
                end
            endcase
            for (k = 0; k < N_RAND / 6; k++) begin
                r = $urandom_range(0, 99);
                if (r < 55) it = rand_spawn();
                else begin
                    it = rand_spawn();
                    it.cmd = (r < 93) ? CMD_TICK : (r < 97) ? CMD_CLEAR : CMD_UNUSED;
                end
                send(it, -1, 0);
            end
        end

        drain();
        if (n_fail == 0 && pending_status.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(64'd300_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule
